### rtl/core/rtmpche_pkg.sv
// Shared types, constants and the control program of the chunk header encoder.
// Used by every module in rtl/core but rtmpche_ram; it depends on nothing else.
package rtmpche_pkg;

  // One request beat on the input channel.
  typedef struct packed {
    logic [5:0]  channel_slot;
    logic [16:0] chunk_stream_id;
    logic [31:0] timestamp;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] stream_id;
    logic        is_absolute;
    logic        first_chunk;
  } in_item_t;

  // One header byte beat on the result channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] header_format;
    logic       bad_channel;
  } out_item_t;

  // Per-slot record of the last header sent.
  typedef struct packed {
    logic [31:0] sid;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] abs_time;
  } rec_t;

  localparam int   REC_W     = $bits(rec_t);
  localparam rec_t REC_RESET = '{sid: '1, ts: '0, len: '0, mtype: '0, abs_time: '0};

  // Header formats.
  localparam logic [1:0] FMT_FULL        = 2'd0;
  localparam logic [1:0] FMT_SAME_STREAM = 2'd1;
  localparam logic [1:0] FMT_SAME_LEN    = 2'd2;
  localparam logic [1:0] FMT_CONT        = 2'd3;

  // Chunk stream id ranges of the basic header.
  localparam logic [16:0] CSID_ONE_LIM   = 17'd64;
  localparam logic [16:0] CSID_TWO_LIM   = 17'd319;
  localparam logic [16:0] CSID_LIMIT     = 17'd65599;
  localparam logic [16:0] CSID_OFFSET    = 17'd64;
  localparam logic [5:0]  CSID_WIDE_MARK = 6'h01;
  localparam logic [31:0] TS_ESCAPE      = 32'h00ff_ffff;

  // Byte sources selected by a control word.
  typedef enum logic [4:0] {
    SRC_BH0, SRC_BH1, SRC_BH2,
    SRC_TS2, SRC_TS1, SRC_TS0,
    SRC_LEN2, SRC_LEN1, SRC_LEN0, SRC_TYPE,
    SRC_SID0, SRC_SID1, SRC_SID2, SRC_SID3,
    SRC_EXT3, SRC_EXT2, SRC_EXT1, SRC_EXT0,
    SRC_ERR
  } src_t;

  // Conditions under which a control word emits its byte.
  typedef enum logic [2:0] {
    C_ALWAYS, C_GOOD, C_BH2, C_BH3, C_F2, C_F1, C_F0, C_EXT
  } cond_t;

  localparam int PC_W      = 5;
  localparam int CNT_W     = 5;
  localparam int UCODE_LEN = 19;

  // Entry points of the program groups.
  localparam logic [PC_W-1:0] PC_TS  = 5'd3;
  localparam logic [PC_W-1:0] PC_LEN = 5'd6;
  localparam logic [PC_W-1:0] PC_SID = 5'd10;
  localparam logic [PC_W-1:0] PC_EXT = 5'd14;
  localparam logic [PC_W-1:0] PC_ERR = 5'd18;
  localparam logic [PC_W-1:0] PC_TOP = 5'd0;

  // A control word: emit src when cond holds, else jump to fail.
  typedef struct packed {
    cond_t           cond;
    src_t            src;
    logic [PC_W-1:0] fail;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic emit;
    logic last;
    src_t src;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] nbytes;
    logic             out_free;
    logic             good;
    logic             bh2;
    logic             bh3;
    logic             f2;
    logic             f1;
    logic             f0;
    logic             ext;
  } stat_t;

  function automatic uword_t mk_word(input cond_t c, input src_t s, input logic [PC_W-1:0] f);
    uword_t w;
    w.cond = c;
    w.src  = s;
    w.fail = f;
    return w;
  endfunction

  // The control program. Each group opens with its condition; the last
  // byte of a header ends the program through the byte count.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = mk_word(C_GOOD,   SRC_BH0,  PC_ERR);
      5'd1:    w = mk_word(C_BH2,    SRC_BH1,  PC_TS);
      5'd2:    w = mk_word(C_BH3,    SRC_BH2,  PC_TS);
      5'd3:    w = mk_word(C_F2,     SRC_TS2,  PC_LEN);
      5'd4:    w = mk_word(C_ALWAYS, SRC_TS1,  PC_TOP);
      5'd5:    w = mk_word(C_ALWAYS, SRC_TS0,  PC_TOP);
      5'd6:    w = mk_word(C_F1,     SRC_LEN2, PC_SID);
      5'd7:    w = mk_word(C_ALWAYS, SRC_LEN1, PC_TOP);
      5'd8:    w = mk_word(C_ALWAYS, SRC_LEN0, PC_TOP);
      5'd9:    w = mk_word(C_ALWAYS, SRC_TYPE, PC_TOP);
      5'd10:   w = mk_word(C_F0,     SRC_SID0, PC_EXT);
      5'd11:   w = mk_word(C_ALWAYS, SRC_SID1, PC_TOP);
      5'd12:   w = mk_word(C_ALWAYS, SRC_SID2, PC_TOP);
      5'd13:   w = mk_word(C_ALWAYS, SRC_SID3, PC_TOP);
      5'd14:   w = mk_word(C_EXT,    SRC_EXT3, PC_TOP);
      5'd15:   w = mk_word(C_ALWAYS, SRC_EXT2, PC_TOP);
      5'd16:   w = mk_word(C_ALWAYS, SRC_EXT1, PC_TOP);
      5'd17:   w = mk_word(C_ALWAYS, SRC_EXT0, PC_TOP);
      5'd18:   w = mk_word(C_ALWAYS, SRC_ERR,  PC_TOP);
      default: w = mk_word(C_ALWAYS, SRC_ERR,  PC_TOP);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/rtmpche_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module rtmpche_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rtmpche_dp.sv
// Datapath of the chunk header encoder: request register, slot records,
// format decision, byte selection and the output register.
// Depends on rtmpche_pkg and rtmpche_ram.
module rtmpche_dp #(
  parameter int CHANNEL_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtmpche_pkg::in_item_t  in_data,
  input  rtmpche_pkg::ctrl_t     ctrl,
  output rtmpche_pkg::stat_t     stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output rtmpche_pkg::out_item_t out_data
);

  // Only as many slots as the slot field can reach need storage.
  localparam int SLOT_SPAN  = 2 ** $bits(in_data.channel_slot);
  localparam int SLOT_DEPTH = (CHANNEL_SLOTS < SLOT_SPAN) ? CHANNEL_SLOTS : SLOT_SPAN;
  localparam int SLOT_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  logic [SLOT_W-1:0]                 slot_map [SLOT_SPAN];
  rtmpche_pkg::in_item_t             in_r;
  logic [SLOT_W-1:0]                 slot_r;
  logic [SLOT_DEPTH-1:0]             valid_r;
  logic [SLOT_DEPTH-1:0]             valid_nxt;
  logic [1:0]                        fmt_r;
  logic [1:0]                        fmt_c;
  logic [rtmpche_pkg::REC_W-1:0]     ram_rdata;
  rtmpche_pkg::rec_t                 rec_old;
  rtmpche_pkg::rec_t                 rec_new;
  logic [31:0]                       abs_c;
  logic                              same_sid;
  logic                              bad;
  logic                              bh2;
  logic                              bh3;
  logic                              ext;
  logic [15:0]                       csid_m64;
  logic [23:0]                       ts24;
  logic [rtmpche_pkg::CNT_W-1:0]     bh_len;
  logic [rtmpche_pkg::CNT_W-1:0]     nbytes_c;
  logic [7:0]                        byte_c;
  logic [5:0]                        bh0_low;
  logic                              out_valid_r;
  rtmpche_pkg::out_item_t            out_r;

  // Slot wrap table, worked out at elaboration.
  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot_map
    assign slot_map[g] = SLOT_W'(g % SLOT_DEPTH);
  end

  // Request register, loaded on an accepted input beat.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      in_r   <= in_data;
      slot_r <= slot_map[in_data.channel_slot];
    end
  end

  // Record store; its read is issued with the accept.
  rtmpche_ram #(
    .WIDTH(rtmpche_pkg::REC_W),
    .DEPTH(SLOT_DEPTH)
  ) u_rec_ram (
    .clk  (clk),
    .we   (ctrl.decide),
    .waddr(slot_r),
    .wdata(rec_new),
    .re   (ctrl.load),
    .raddr(slot_map[in_data.channel_slot]),
    .rdata(ram_rdata)
  );

  // A slot never written reads as its reset record.
  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.decide) begin
      valid_nxt[slot_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Format decision and record update.
  always_comb begin
    rec_old  = valid_r[slot_r] ? rtmpche_pkg::rec_t'(ram_rdata) : rtmpche_pkg::REC_RESET;
    same_sid = (rec_old.sid == in_r.stream_id);
    fmt_c    = rtmpche_pkg::FMT_FULL;
    abs_c    = in_r.timestamp;
    if (!same_sid) begin
      fmt_c = rtmpche_pkg::FMT_FULL;
      abs_c = in_r.timestamp;
    end else if (in_r.is_absolute) begin
      if (in_r.first_chunk) begin
        fmt_c = rtmpche_pkg::FMT_FULL;
        abs_c = in_r.timestamp;
      end else begin
        fmt_c = rtmpche_pkg::FMT_CONT;
        abs_c = rec_old.abs_time;
      end
    end else if (in_r.first_chunk) begin
      fmt_c = rtmpche_pkg::FMT_SAME_STREAM;
      if ((in_r.message_type == rec_old.mtype) && (in_r.message_length == rec_old.len)) begin
        fmt_c = (in_r.timestamp == rec_old.ts) ? rtmpche_pkg::FMT_CONT
                                               : rtmpche_pkg::FMT_SAME_LEN;
      end
      abs_c = rec_old.abs_time + in_r.timestamp;
    end else begin
      fmt_c = rtmpche_pkg::FMT_CONT;
      abs_c = rec_old.abs_time;
    end
    rec_new.sid      = in_r.stream_id;
    rec_new.ts       = in_r.timestamp;
    rec_new.len      = in_r.message_length;
    rec_new.mtype    = in_r.message_type;
    rec_new.abs_time = abs_c;
  end

  always_ff @(posedge clk) begin
    if (ctrl.decide) begin
      fmt_r <= fmt_c;
    end
  end

  // Header shape flags from the held request.
  assign bad      = (in_r.chunk_stream_id >= rtmpche_pkg::CSID_LIMIT);
  assign bh2      = (in_r.chunk_stream_id >= rtmpche_pkg::CSID_ONE_LIM);
  assign bh3      = (in_r.chunk_stream_id >= rtmpche_pkg::CSID_TWO_LIM);
  assign ext      = (in_r.timestamp >= rtmpche_pkg::TS_ESCAPE);
  assign csid_m64 = 16'(in_r.chunk_stream_id - rtmpche_pkg::CSID_OFFSET);
  assign ts24     = ext ? rtmpche_pkg::TS_ESCAPE[23:0] : in_r.timestamp[23:0];

  // Byte count of the header, taken by the sequencer while deciding.
  always_comb begin
    bh_len = bh3 ? rtmpche_pkg::CNT_W'(3) : (bh2 ? rtmpche_pkg::CNT_W'(2)
                                                 : rtmpche_pkg::CNT_W'(1));
    nbytes_c = bh_len;
    if (fmt_c != rtmpche_pkg::FMT_CONT) begin
      nbytes_c = nbytes_c + rtmpche_pkg::CNT_W'(3);
    end
    if ((fmt_c == rtmpche_pkg::FMT_FULL) || (fmt_c == rtmpche_pkg::FMT_SAME_STREAM)) begin
      nbytes_c = nbytes_c + rtmpche_pkg::CNT_W'(4);
    end
    if (fmt_c == rtmpche_pkg::FMT_FULL) begin
      nbytes_c = nbytes_c + rtmpche_pkg::CNT_W'(4);
    end
    if (ext) begin
      nbytes_c = nbytes_c + rtmpche_pkg::CNT_W'(4);
    end
    if (bad) begin
      nbytes_c = rtmpche_pkg::CNT_W'(1);
    end
  end

  assign stat.nbytes   = nbytes_c;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.good     = !bad;
  assign stat.bh2      = bh2;
  assign stat.bh3      = bh3;
  assign stat.f2       = (fmt_r != rtmpche_pkg::FMT_CONT);
  assign stat.f1       = (fmt_r == rtmpche_pkg::FMT_FULL) ||
                         (fmt_r == rtmpche_pkg::FMT_SAME_STREAM);
  assign stat.f0       = (fmt_r == rtmpche_pkg::FMT_FULL);
  assign stat.ext      = ext;

  // Byte selection for the current control word.
  always_comb begin
    if (bh3) begin
      bh0_low = rtmpche_pkg::CSID_WIDE_MARK;
    end else if (bh2) begin
      bh0_low = '0;
    end else begin
      bh0_low = in_r.chunk_stream_id[5:0];
    end
    unique case (ctrl.src)
      rtmpche_pkg::SRC_BH0:  byte_c = {fmt_r, bh0_low};
      rtmpche_pkg::SRC_BH1:  byte_c = csid_m64[7:0];
      rtmpche_pkg::SRC_BH2:  byte_c = csid_m64[15:8];
      rtmpche_pkg::SRC_TS2:  byte_c = ts24[23:16];
      rtmpche_pkg::SRC_TS1:  byte_c = ts24[15:8];
      rtmpche_pkg::SRC_TS0:  byte_c = ts24[7:0];
      rtmpche_pkg::SRC_LEN2: byte_c = in_r.message_length[23:16];
      rtmpche_pkg::SRC_LEN1: byte_c = in_r.message_length[15:8];
      rtmpche_pkg::SRC_LEN0: byte_c = in_r.message_length[7:0];
      rtmpche_pkg::SRC_TYPE: byte_c = in_r.message_type;
      rtmpche_pkg::SRC_SID0: byte_c = in_r.stream_id[7:0];
      rtmpche_pkg::SRC_SID1: byte_c = in_r.stream_id[15:8];
      rtmpche_pkg::SRC_SID2: byte_c = in_r.stream_id[23:16];
      rtmpche_pkg::SRC_SID3: byte_c = in_r.stream_id[31:24];
      rtmpche_pkg::SRC_EXT3: byte_c = in_r.timestamp[31:24];
      rtmpche_pkg::SRC_EXT2: byte_c = in_r.timestamp[23:16];
      rtmpche_pkg::SRC_EXT1: byte_c = in_r.timestamp[15:8];
      rtmpche_pkg::SRC_EXT0: byte_c = in_r.timestamp[7:0];
      default:               byte_c = '0;
    endcase
  end

  // Output register; a new beat loads while the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_r.out_byte      <= byte_c;
      out_r.last_byte     <= ctrl.last;
      out_r.header_format <= fmt_r;
      out_r.bad_channel   <= (ctrl.src == rtmpche_pkg::SRC_ERR);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/rtmpche_seq.sv
// Microcoded sequencer of the chunk header encoder: state, program counter,
// byte count and condition tests. Depends on rtmpche_pkg.
module rtmpche_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtmpche_pkg::stat_t stat,
  output rtmpche_pkg::ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [rtmpche_pkg::PC_W-1:0]  pc_r;
  logic [rtmpche_pkg::PC_W-1:0]  pc_nxt;
  logic [rtmpche_pkg::CNT_W-1:0] rem_r;
  logic [rtmpche_pkg::CNT_W-1:0] rem_nxt;
  rtmpche_pkg::uword_t           word;
  logic                          take;
  logic                          emit;
  logic                          last;

  // Fetch the control word and test its condition.
  always_comb begin
    word = rtmpche_pkg::ucode(pc_r);
    unique case (word.cond)
      rtmpche_pkg::C_ALWAYS: take = 1'b1;
      rtmpche_pkg::C_GOOD:   take = stat.good;
      rtmpche_pkg::C_BH2:    take = stat.bh2;
      rtmpche_pkg::C_BH3:    take = stat.bh3;
      rtmpche_pkg::C_F2:     take = stat.f2;
      rtmpche_pkg::C_F1:     take = stat.f1;
      rtmpche_pkg::C_F0:     take = stat.f0;
      rtmpche_pkg::C_EXT:    take = stat.ext;
      default:               take = 1'b0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign emit     = (state_r == ST_RUN) && take && stat.out_free;
  assign last     = (rem_r == rtmpche_pkg::CNT_W'(1));

  // Step, jump and end of program.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        pc_nxt    = rtmpche_pkg::PC_TOP;
        rem_nxt   = stat.nbytes;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!take) begin
          pc_nxt = word.fail;
        end else if (stat.out_free) begin
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            pc_nxt  = pc_r + rtmpche_pkg::PC_W'(1);
            rem_nxt = rem_r - rtmpche_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign ctrl.load   = in_valid && in_ready;
  assign ctrl.decide = (state_r == ST_DECIDE);
  assign ctrl.emit   = emit;
  assign ctrl.last   = last;
  assign ctrl.src    = word.src;

  // The byte count never runs out while the program is active.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rem_r != '0))
    else $error("byte count empty while emitting");

  // The program counter stays inside the program.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (pc_r < rtmpche_pkg::PC_W'(rtmpche_pkg::UCODE_LEN)))
    else $error("program counter left the program");

  // The final beat of a header returns the sequencer to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after the last beat");

  // An accepted request is decided in the next cycle.
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECIDE))
    else $error("accepted request not decided");

endmodule

### rtl/core/rtmp_chunk_header_encoder.sv
// RTMP chunk header encoder with per-slot header compression.
// A request passes the decide and run states before its first byte is registered, and an
// error header jumps to the error word first. Headers are 1 to 18 bytes; a new request is
// taken after the last byte. The microcode sequencer emits at most one byte a cycle.
// Reset (rst_n, synchronous, active low) idles the sequencer and marks every slot
// record as unused; no clearing pass is needed.
module rtmp_chunk_header_encoder #(
  parameter int CHANNEL_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rtmpche_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtmpche_pkg::out_item_t out_data
);

  rtmpche_pkg::ctrl_t ctrl;
  rtmpche_pkg::stat_t stat;

  // Control program and step counter.
  rtmpche_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  // Records, format decision and byte output.
  rtmpche_dp #(
    .CHANNEL_SLOTS(CHANNEL_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

### tb/tb_rtmp_chunk_header_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RTMP chunk header encoder: directed header cases, then
// random message traffic under varied flow control. Depends on rtmpche_pkg and the encoder.
module tb_rtmp_chunk_header_encoder;

  localparam int SLOT_COUNT     = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int PHASE_ITEMS    = 76;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  rtmpche_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rtmpche_pkg::out_item_t out_data;

  // Flow control percentages of the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Predicted header bytes still to come, oldest first.
  rtmpche_pkg::out_item_t hdr_byte_q[$];
  rtmpche_pkg::out_item_t next_want;

  // Per-slot header records of the predictor.
  logic [31:0] rec_sid  [SLOT_COUNT];
  logic [31:0] rec_ts   [SLOT_COUNT];
  logic [23:0] rec_len  [SLOT_COUNT];
  logic [7:0]  rec_type [SLOT_COUNT];
  logic [31:0] rec_abs  [SLOT_COUNT];

  // Per-slot memory of the traffic generator, so that headers repeat and compress.
  logic [31:0] gen_sid  [SLOT_COUNT];
  logic [31:0] gen_ts   [SLOT_COUNT];
  logic [23:0] gen_len  [SLOT_COUNT];
  logic [7:0]  gen_type [SLOT_COUNT];

  int fail_count    = 0;
  int req_count     = 0;
  int err_req_count = 0;
  int bytes_checked = 0;
  int fmt_seen [4]  = '{0, 0, 0, 0};
  int stall_cycles  = 0;

  rtmp_chunk_header_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic rtmpche_pkg::in_item_t make_request(
      input logic [5:0] slot, input logic [16:0] csid, input logic [31:0] ts,
      input logic [23:0] len, input logic [7:0] mtype, input logic [31:0] sid,
      input logic absolute, input logic first);
    rtmpche_pkg::in_item_t req;
    req.channel_slot    = slot;
    req.chunk_stream_id = csid;
    req.timestamp       = ts;
    req.message_length  = len;
    req.message_type    = mtype;
    req.stream_id       = sid;
    req.is_absolute     = absolute;
    req.first_chunk     = first;
    return req;
  endfunction

  // Picks the header format against the slot record, updates the record and
  // queues the serialized header bytes that the request should produce.
  task automatic predict_header(input rtmpche_pkg::in_item_t req);
    logic [5:0]             slot;
    logic [1:0]             fmt;
    logic [16:0]            csid_off;
    logic [23:0]            ts24;
    logic [7:0]             hdr[$];
    bit                     long_ts;
    rtmpche_pkg::out_item_t beat;
    slot = req.channel_slot;

    // Format choice and running time update.
    if (rec_sid[slot] != req.stream_id) begin
      fmt = rtmpche_pkg::FMT_FULL;
      rec_sid[slot] = req.stream_id;
      rec_abs[slot] = req.timestamp;
    end else if (!req.first_chunk) begin
      fmt = rtmpche_pkg::FMT_CONT;
    end else if (req.is_absolute) begin
      fmt = rtmpche_pkg::FMT_FULL;
      rec_abs[slot] = req.timestamp;
    end else begin
      fmt = rtmpche_pkg::FMT_SAME_STREAM;
      if (req.message_type == rec_type[slot] && req.message_length == rec_len[slot]) begin
        fmt = rtmpche_pkg::FMT_SAME_LEN;
        if (req.timestamp == rec_ts[slot]) begin
          fmt = rtmpche_pkg::FMT_CONT;
        end
      end
      rec_abs[slot] = rec_abs[slot] + req.timestamp;
    end
    rec_ts[slot]   = req.timestamp;
    rec_len[slot]  = req.message_length;
    rec_type[slot] = req.message_type;
    req_count++;
    fmt_seen[fmt]++;

    if (req.chunk_stream_id >= rtmpche_pkg::CSID_LIMIT) begin
      // An out-of-range chunk stream id gives a single error beat.
      err_req_count++;
      beat = '{out_byte: 8'h00, last_byte: 1'b1, header_format: fmt, bad_channel: 1'b1};
      hdr_byte_q.push_back(beat);
    end else begin
      // Basic header: one, two or three bytes by chunk stream id range.
      csid_off = req.chunk_stream_id - rtmpche_pkg::CSID_OFFSET;
      if (req.chunk_stream_id < rtmpche_pkg::CSID_ONE_LIM) begin
        hdr.push_back({fmt, req.chunk_stream_id[5:0]});
      end else if (req.chunk_stream_id < rtmpche_pkg::CSID_TWO_LIM) begin
        hdr.push_back({fmt, 6'd0});
        hdr.push_back(csid_off[7:0]);
      end else begin
        hdr.push_back({fmt, rtmpche_pkg::CSID_WIDE_MARK});
        hdr.push_back(csid_off[7:0]);
        hdr.push_back(csid_off[15:8]);
      end

      // Message header, shrinking with the format.
      long_ts = (req.timestamp >= rtmpche_pkg::TS_ESCAPE);
      ts24 = long_ts ? rtmpche_pkg::TS_ESCAPE[23:0] : req.timestamp[23:0];
      if (fmt != rtmpche_pkg::FMT_CONT) begin
        hdr.push_back(ts24[23:16]);
        hdr.push_back(ts24[15:8]);
        hdr.push_back(ts24[7:0]);
      end
      if (fmt == rtmpche_pkg::FMT_FULL || fmt == rtmpche_pkg::FMT_SAME_STREAM) begin
        hdr.push_back(req.message_length[23:16]);
        hdr.push_back(req.message_length[15:8]);
        hdr.push_back(req.message_length[7:0]);
        hdr.push_back(req.message_type);
      end
      if (fmt == rtmpche_pkg::FMT_FULL) begin
        hdr.push_back(req.stream_id[7:0]);
        hdr.push_back(req.stream_id[15:8]);
        hdr.push_back(req.stream_id[23:16]);
        hdr.push_back(req.stream_id[31:24]);
      end

      // Extended timestamp follows for every format once the 24-bit field escapes.
      if (long_ts) begin
        hdr.push_back(req.timestamp[31:24]);
        hdr.push_back(req.timestamp[23:16]);
        hdr.push_back(req.timestamp[15:8]);
        hdr.push_back(req.timestamp[7:0]);
      end

      foreach (hdr[i]) begin
        beat = '{out_byte: hdr[i], last_byte: (i == hdr.size() - 1), header_format: fmt,
                 bad_channel: 1'b0};
        hdr_byte_q.push_back(beat);
      end
    end
  endtask

  // Every accepted request beat feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_header(in_data);
    end
  end

  // Each accepted result beat is compared with the oldest predicted byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (hdr_byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%h last=%b fmt=%0d bad=%b",
                                  out_data.out_byte, out_data.last_byte,
                                  out_data.header_format, out_data.bad_channel));
      end else begin
        next_want = hdr_byte_q.pop_front();
        if (out_data.out_byte !== next_want.out_byte) begin
          report_mismatch($sformatf("beat %0d out_byte %h, expected %h", bytes_checked,
                                    out_data.out_byte, next_want.out_byte));
        end
        if (out_data.last_byte !== next_want.last_byte) begin
          report_mismatch($sformatf("beat %0d last_byte %b, expected %b", bytes_checked,
                                    out_data.last_byte, next_want.last_byte));
        end
        if (out_data.header_format !== next_want.header_format) begin
          report_mismatch($sformatf("beat %0d header_format %0d, expected %0d", bytes_checked,
                                    out_data.header_format, next_want.header_format));
        end
        if (out_data.bad_channel !== next_want.bad_channel) begin
          report_mismatch($sformatf("beat %0d bad_channel %b, expected %b", bytes_checked,
                                    out_data.bad_channel, next_want.bad_channel));
        end
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sends one request beat, with random idle cycles ahead of it. Valid is left
  // high on return; the caller sends again or drains in the same time step.
  task automatic send_request(input rtmpche_pkg::in_item_t req);
    bit idled;
    idled = 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (!idled) begin
        in_valid <= 1'b0;
      end
      idled = 1'b1;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Drops valid and waits until every predicted byte has arrived.
  task automatic wait_for_headers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hdr_byte_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Basic header widths at every chunk stream id boundary, plus field extremes.
  task automatic test_basic_header_widths();
    send_request(make_request(6'd1, 17'd0, 32'h0, 24'h0, 8'h00, 32'h0, 1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd63, 32'h00FF_FFFE, 24'hFF_FFFF, 8'hFF, 32'h0,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd64, 32'h12, 24'h00_0001, 8'h01, 32'hFFFF_FFFE,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd318, 32'h34, 24'h80_0000, 8'h80, 32'hFFFF_FFFE,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd319, 32'h56, 24'h12_3456, 8'h14, 32'hA5A5_5A5A,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd65598, 32'h78, 24'h65_4321, 8'h12, 32'hA5A5_5A5A,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'd65599, 32'h9A, 24'h00_0010, 8'h09, 32'hA5A5_5A5A,
                              1'b1, 1'b1));
    send_request(make_request(6'd1, 17'h1FFFF, 32'hBC, 24'h00_0010, 8'h09, 32'h0000_0001,
                              1'b0, 1'b1));
  endtask

  // Walks one slot through every format choice.
  task automatic test_format_selection();
    send_request(make_request(6'd2, 17'd3, 32'd100, 24'd10, 8'd9, 32'd7, 1'b1, 1'b1));
    send_request(make_request(6'd2, 17'd3, 32'd20, 24'd11, 8'd9, 32'd7, 1'b0, 1'b1));
    send_request(make_request(6'd2, 17'd3, 32'd30, 24'd11, 8'd9, 32'd7, 1'b0, 1'b1));
    send_request(make_request(6'd2, 17'd3, 32'd30, 24'd11, 8'd9, 32'd7, 1'b0, 1'b1));
    send_request(make_request(6'd2, 17'd3, 32'd30, 24'd11, 8'd9, 32'd7, 1'b1, 1'b0));
    send_request(make_request(6'd2, 17'd3, 32'd30, 24'd11, 8'd9, 32'd7, 1'b0, 1'b0));
    send_request(make_request(6'd2, 17'd3, 32'd40, 24'd11, 8'd9, 32'd7, 1'b1, 1'b1));
    send_request(make_request(6'd2, 17'd3, 32'd40, 24'd11, 8'd9, 32'd8, 1'b0, 1'b1));
  endtask

  // Timestamps around the escape value, in every format.
  task automatic test_extended_timestamp();
    send_request(make_request(6'd3, 17'd320, 32'h00FF_FFFE, 24'd5, 8'd8, 32'd3, 1'b1, 1'b1));
    send_request(make_request(6'd3, 17'd320, 32'h00FF_FFFF, 24'd6, 8'd8, 32'd3, 1'b0, 1'b1));
    send_request(make_request(6'd3, 17'd320, 32'hFFFF_FFFF, 24'd6, 8'd8, 32'd3, 1'b0, 1'b1));
    send_request(make_request(6'd3, 17'd320, 32'hFFFF_FFFF, 24'd6, 8'd8, 32'd3, 1'b0, 1'b1));
    send_request(make_request(6'd3, 17'd320, 32'hFFFF_FFFF, 24'd6, 8'd8, 32'd3, 1'b0, 1'b0));
  endtask

  // A stream id of all ones on a fresh slot matches the unused mark.
  task automatic test_unused_stream_mark();
    send_request(make_request(6'd63, 17'd2, 32'd0, 24'd0, 8'd0, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_request(make_request(6'd63, 17'd2, 32'd9, 24'd4, 8'd1, 32'hFFFF_FFFF, 1'b1, 1'b0));
  endtask

  // An error header still updates the record, so the follow-up fully compresses.
  task automatic test_error_updates_record();
    send_request(make_request(6'd4, 17'd70000, 32'd55, 24'd66, 8'd7, 32'd5, 1'b0, 1'b1));
    send_request(make_request(6'd4, 17'd5, 32'd55, 24'd66, 8'd7, 32'd5, 1'b0, 1'b1));
  endtask

  function automatic logic [16:0] pick_chunk_stream();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 17'($urandom_range(0, 63));
    end else if (r < 70) begin
      return 17'($urandom_range(64, 318));
    end else if (r < 95) begin
      return 17'($urandom_range(319, 65598));
    end
    return 17'($urandom_range(65599, 131071));
  endfunction

  // Random traffic: mostly messages on a few busy slots (a first chunk plus
  // continuations, reusing stream, length, type and time so headers compress),
  // the rest fully random requests.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int budget);
    rtmpche_pkg::in_item_t req;
    logic [5:0]            slot;
    int                    sent;
    int                    conts;
    int                    r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        req = make_request(6'($urandom), 17'($urandom), $urandom, 24'($urandom),
                           8'($urandom), $urandom, 1'($urandom), 1'($urandom));
        send_request(req);
        sent++;
      end else begin
        slot = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 10) begin
          gen_sid[slot] = 32'hFFFF_FFFF;
        end else if (r < 30) begin
          gen_sid[slot] = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
          gen_len[slot] = 24'($urandom_range(0, 4095));
        end else if (r < 60) begin
          gen_len[slot] = 24'($urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
          gen_type[slot] = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
          gen_ts[slot] = $urandom_range(0, 2000);
        end else if (r < 50) begin
          gen_ts[slot] = $urandom;
        end else if (r < 65) begin
          gen_ts[slot] = rtmpche_pkg::TS_ESCAPE - 2 + $urandom_range(0, 4);
        end
        req = make_request(slot, pick_chunk_stream(), gen_ts[slot], gen_len[slot],
                           gen_type[slot], gen_sid[slot], ($urandom_range(0, 99) < 30),
                           1'b1);
        send_request(req);
        sent++;
        // Continuation chunks of the same message.
        conts = $urandom_range(0, 3);
        for (int k = 0; k < conts; k++) begin
          req.first_chunk = 1'b0;
          req.is_absolute = 1'($urandom);
          send_request(req);
          sent++;
        end
      end
    end
    wait_for_headers();
  endtask

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      rec_sid[s]  = 32'hFFFF_FFFF;
      rec_ts[s]   = '0;
      rec_len[s]  = '0;
      rec_type[s] = '0;
      rec_abs[s]  = '0;
      gen_sid[s]  = $urandom;
      gen_ts[s]   = '0;
      gen_len[s]  = '0;
      gen_type[s] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases with free-running flow control.
    test_basic_header_widths();
    wait_for_headers();
    test_format_selection();
    wait_for_headers();
    test_extended_timestamp();
    wait_for_headers();
    test_unused_stream_mark();
    wait_for_headers();
    test_error_updates_record();
    wait_for_headers();

    // Random phases: no idling, sender idle, receiver stalling, light idling on both.
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(70, 0, PHASE_ITEMS);
    test_random_traffic(0, 70, PHASE_ITEMS);
    test_random_traffic(6, 6, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d header requests (%0d with a bad chunk stream id), %0d bytes.",
             req_count, err_req_count, bytes_checked);
    $display("Formats seen: full %0d, same stream %0d, same length %0d, continuation %0d.",
             fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### rtmp_chunk_header_encoder.f
rtl/core/rtmpche_pkg.sv
rtl/core/rtmpche_ram.sv
rtl/core/rtmpche_dp.sv
rtl/core/rtmpche_seq.sv
rtl/core/rtmp_chunk_header_encoder.sv
tb/tb_rtmp_chunk_header_encoder.sv
